>>> rtl/loim_pkg.sv
// shared types and constants of the linear ordering insertion-move engine
package loim_pkg;

  // fixed field widths
  localparam int OBJ_W     = 48;
  localparam int ID_W      = 6;
  localparam int CMD_W     = 3;
  localparam int SIZE_W    = 7;
  localparam int PDATA_W   = 32;
  localparam int PADDR_W   = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WR_WEIGHT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WR_PERM   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_OBJECTIVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MOVE      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

  // register byte address
  localparam logic [PADDR_W-1:0] ADDR_ACTIVE_SIZE = 2'd0;

  // reset value of the active size register
  localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RST = 7'd64;

  // control of the shared accumulator
  typedef struct packed {
    logic clear;
    logic en;
    logic sub;
    logic sel_obj;
  } alu_ctl_t;

endpackage

>>> rtl/loim_alu.sv
// shared 48-bit add/subtract accumulator for objective and gain sums
module loim_alu import loim_pkg::*; #(
  parameter int WEIGHT_BITS = 32
) (
  input  logic                   clk,
  input  alu_ctl_t               ctl,
  input  logic [WEIGHT_BITS-1:0] weight,
  input  logic [OBJ_W-1:0]       objective,
  output logic [OBJ_W-1:0]       acc
);

  logic [OBJ_W-1:0] operand;
  logic [OBJ_W-1:0] sum;

  // operand select: sign-extended weight or stored objective
  always_comb begin
    if (ctl.sel_obj) begin
      operand = objective;
    end else begin
      operand = {{(OBJ_W-WEIGHT_BITS){weight[WEIGHT_BITS-1]}}, weight};
    end
    sum = ctl.sub ? (acc - operand) : (acc + operand);
  end

  // accumulator register
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.en) begin
      acc <= sum;
    end
  end

endmodule

>>> rtl/linear_ordering_insertion_move.sv
// top level: sequencer, weight and permutation memories, result register
//
// channel   direction  handshake            payload
// ------    ---------  ---------            -------
// config    in         psel/penable/pwrite  paddr, pwdata (prdata back)
// request   in         in_valid/in_stall    command, indexes, weight, positions
// result    out        out_valid/out_stall  objective, delta, accepted, read item
//
// objective: sums one weight per position pair a < b through the one weight read port
// move: evaluates the gain over the crossed items, then applies the move if it gains
// rst is synchronous; memories come up undefined and must be written before use
// in_stall is high from the accepted request until its result enters the output register;
// a new request is taken while an earlier result still waits on out_stall
module linear_ordering_insertion_move import loim_pkg::*; #(
  parameter int MAX_ITEMS   = 64,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CMD_W-1:0]          command,
  input  logic [ID_W-1:0]           row_index,
  input  logic [ID_W-1:0]           col_index,
  input  logic signed [31:0]        weight_value,
  input  logic [ID_W-1:0]           position,
  input  logic [ID_W-1:0]           item_id,
  input  logic [ID_W-1:0]           move_from,
  input  logic [ID_W-1:0]           move_to,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [OBJ_W-1:0]   objective_value,
  output logic signed [OBJ_W-1:0]   move_delta,
  output logic                      move_accepted,
  output logic [ID_W-1:0]           read_item
);

  localparam int IDX_W   = $clog2(MAX_ITEMS);
  localparam int SZ_W    = (IDX_W + 1 > SIZE_W) ? IDX_W + 1 : SIZE_W;
  localparam int WA_W    = 2 * IDX_W;
  localparam int W_DEPTH = 1 << WA_W;

  localparam logic [SZ_W-1:0] MAX_N = SZ_W'(MAX_ITEMS);

  // sequencer states
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_FIN  = 5'd1;
  localparam logic [4:0] S_OA   = 5'd2;
  localparam logic [4:0] S_OB   = 5'd3;
  localparam logic [4:0] S_OW   = 5'd4;
  localparam logic [4:0] S_OACC = 5'd5;
  localparam logic [4:0] S_ODN  = 5'd6;
  localparam logic [4:0] S_MF   = 5'd7;
  localparam logic [4:0] S_MI   = 5'd8;
  localparam logic [4:0] S_MK   = 5'd9;
  localparam logic [4:0] S_MW1  = 5'd10;
  localparam logic [4:0] S_MW2  = 5'd11;
  localparam logic [4:0] S_MW3  = 5'd12;
  localparam logic [4:0] S_MDEC = 5'd13;
  localparam logic [4:0] S_SR   = 5'd14;
  localparam logic [4:0] S_SW   = 5'd15;
  localparam logic [4:0] S_RD   = 5'd16;

  // control and work registers
  logic [4:0]             state, state_next;
  logic [SIZE_W-1:0]      active_size;
  logic [OBJ_W-1:0]       objective, objective_next;
  logic [SZ_W-1:0]        a_cnt, a_next;
  logic [SZ_W-1:0]        b_cnt, b_next;
  logic [SZ_W-1:0]        k_cnt, k_next;
  logic [SZ_W-1:0]        from_pos, from_next;
  logic [SZ_W-1:0]        to_pos, to_next;
  logic                   fwd, fwd_next;
  logic [ID_W-1:0]        it, it_next;
  logic [ID_W-1:0]        pk, pk_next;
  logic [ID_W-1:0]        pa, pa_next;
  logic [OBJ_W-1:0]       delta, delta_next;
  logic                   accepted, accepted_next;
  logic [ID_W-1:0]        read_r, read_next;

  // memory ports
  logic                   p_we;
  logic [IDX_W-1:0]       p_waddr, p_raddr;
  logic [ID_W-1:0]        p_wdata, p_rdata;
  logic                   w_we;
  logic [WA_W-1:0]        w_waddr, w_raddr;
  logic [WEIGHT_BITS-1:0] w_wdata, w_rdata;

  logic [ID_W-1:0]        perm_mem [MAX_ITEMS];
  logic [WEIGHT_BITS-1:0] weight_mem [W_DEPTH];

  // shared accumulator
  alu_ctl_t               alu_ctl;
  logic [OBJ_W-1:0]       alu_acc;

  // derived values
  logic [SZ_W-1:0]        n_eff, size_ext;
  logic [SZ_W-1:0]        a_inc, b_inc, k_inc, k_dec;
  logic [SZ_W-1:0]        from_ext, to_ext;
  logic                   row_ok, col_ok, pos_ok, item_ok;
  logic                   gain_pos, out_free;

  loim_alu #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_alu (
    .clk       (clk),
    .ctl       (alu_ctl),
    .weight    (w_rdata),
    .objective (objective),
    .acc       (alu_acc)
  );

  // configuration register
  assign pready = 1'b1;
  always_comb begin
    if (paddr == ADDR_ACTIVE_SIZE) begin
      prdata = {{(PDATA_W-SIZE_W){1'b0}}, active_size};
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= ACTIVE_SIZE_RST;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_ACTIVE_SIZE) begin
      active_size <= pwdata[SIZE_W-1:0];
    end
  end

  // effective size and index helpers
  always_comb begin
    size_ext = SZ_W'(active_size);
    n_eff    = (size_ext > MAX_N) ? MAX_N : size_ext;
    a_inc    = a_cnt + SZ_W'(1);
    b_inc    = b_cnt + SZ_W'(1);
    k_inc    = k_cnt + SZ_W'(1);
    k_dec    = k_cnt - SZ_W'(1);
    from_ext = SZ_W'(move_from);
    to_ext   = SZ_W'(move_to);
    row_ok   = SZ_W'(row_index) < MAX_N;
    col_ok   = SZ_W'(col_index) < MAX_N;
    pos_ok   = SZ_W'(position) < MAX_N;
    item_ok  = SZ_W'(item_id) < MAX_N;
    gain_pos = !alu_acc[OBJ_W-1] && (alu_acc != '0);
    out_free = !out_valid || !out_stall;
  end

  assign in_stall = (state != S_IDLE);

  // sequencer
  always_comb begin
    state_next     = state;
    objective_next = objective;
    a_next         = a_cnt;
    b_next         = b_cnt;
    k_next         = k_cnt;
    from_next      = from_pos;
    to_next        = to_pos;
    fwd_next       = fwd;
    it_next        = it;
    pk_next        = pk;
    pa_next        = pa;
    delta_next     = delta;
    accepted_next  = accepted;
    read_next      = read_r;
    p_we           = 1'b0;
    p_waddr        = '0;
    p_wdata        = '0;
    p_raddr        = '0;
    w_we           = 1'b0;
    w_waddr        = '0;
    w_wdata        = '0;
    w_raddr        = '0;
    alu_ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          delta_next    = '0;
          accepted_next = 1'b0;
          read_next     = '0;
          state_next    = S_FIN;
          unique case (command)
            CMD_WR_WEIGHT: begin
              if (row_ok && col_ok) begin
                w_we    = 1'b1;
                w_waddr = {IDX_W'(row_index), IDX_W'(col_index)};
                w_wdata = weight_value[WEIGHT_BITS-1:0];
              end
            end
            CMD_WR_PERM: begin
              if (pos_ok && item_ok) begin
                p_we    = 1'b1;
                p_waddr = IDX_W'(position);
                p_wdata = item_id;
              end
            end
            CMD_OBJECTIVE: begin
              if (n_eff < SZ_W'(2)) begin
                objective_next = '0;
              end else begin
                alu_ctl.clear = 1'b1;
                a_next        = '0;
                state_next    = S_OA;
              end
            end
            CMD_MOVE: begin
              if (from_ext < n_eff && to_ext < n_eff && from_ext != to_ext) begin
                from_next     = from_ext;
                to_next       = to_ext;
                fwd_next      = from_ext < to_ext;
                alu_ctl.clear = 1'b1;
                state_next    = S_MF;
              end
            end
            CMD_READ: begin
              if (pos_ok) begin
                p_raddr    = IDX_W'(position);
                state_next = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // objective: outer position a, inner position b over all pairs
      S_OA: begin
        p_raddr    = a_cnt[IDX_W-1:0];
        b_next     = a_inc;
        state_next = S_OB;
      end
      S_OB: begin
        pa_next    = p_rdata;
        p_raddr    = b_cnt[IDX_W-1:0];
        state_next = S_OW;
      end
      S_OW: begin
        w_raddr    = {IDX_W'(pa), IDX_W'(p_rdata)};
        state_next = S_OACC;
      end
      S_OACC: begin
        alu_ctl.en = 1'b1;
        if (b_cnt == n_eff - SZ_W'(1)) begin
          if (a_cnt == n_eff - SZ_W'(2)) begin
            state_next = S_ODN;
          end else begin
            a_next     = a_inc;
            state_next = S_OA;
          end
        end else begin
          b_next     = b_inc;
          p_raddr    = b_inc[IDX_W-1:0];
          state_next = S_OW;
        end
      end
      S_ODN: begin
        objective_next = alu_acc;
        state_next     = S_FIN;
      end
      // move evaluation over the crossed positions
      S_MF: begin
        p_raddr    = from_pos[IDX_W-1:0];
        state_next = S_MI;
      end
      S_MI: begin
        it_next    = p_rdata;
        k_next     = fwd ? (from_pos + SZ_W'(1)) : to_pos;
        state_next = S_MK;
      end
      S_MK: begin
        p_raddr    = k_cnt[IDX_W-1:0];
        state_next = S_MW1;
      end
      S_MW1: begin
        pk_next = p_rdata;
        if (fwd) begin
          w_raddr = {IDX_W'(p_rdata), IDX_W'(it)};
        end else begin
          w_raddr = {IDX_W'(it), IDX_W'(p_rdata)};
        end
        state_next = S_MW2;
      end
      S_MW2: begin
        alu_ctl.en = 1'b1;
        if (fwd) begin
          w_raddr = {IDX_W'(it), IDX_W'(pk)};
        end else begin
          w_raddr = {IDX_W'(pk), IDX_W'(it)};
        end
        state_next = S_MW3;
      end
      S_MW3: begin
        alu_ctl.en  = 1'b1;
        alu_ctl.sub = 1'b1;
        if (fwd ? (k_cnt == to_pos) : (k_inc == from_pos)) begin
          state_next = S_MDEC;
        end else begin
          k_next     = k_inc;
          p_raddr    = k_inc[IDX_W-1:0];
          state_next = S_MW1;
        end
      end
      S_MDEC: begin
        delta_next = alu_acc;
        if (gain_pos) begin
          accepted_next   = 1'b1;
          alu_ctl.en      = 1'b1;
          alu_ctl.sel_obj = 1'b1;
          k_next          = from_pos;
          state_next      = S_SR;
        end else begin
          state_next = S_FIN;
        end
      end
      // shift the permutation one entry per step, then drop the item in
      S_SR: begin
        if (k_cnt == to_pos) begin
          p_we           = 1'b1;
          p_waddr        = to_pos[IDX_W-1:0];
          p_wdata        = it;
          objective_next = alu_acc;
          state_next     = S_FIN;
        end else begin
          p_raddr    = fwd ? k_inc[IDX_W-1:0] : k_dec[IDX_W-1:0];
          state_next = S_SW;
        end
      end
      S_SW: begin
        p_we       = 1'b1;
        p_waddr    = k_cnt[IDX_W-1:0];
        p_wdata    = p_rdata;
        k_next     = fwd ? k_inc : k_dec;
        state_next = S_SR;
      end
      S_RD: begin
        read_next  = p_rdata;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state and objective
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      objective <= '0;
    end else begin
      state     <= state_next;
      objective <= objective_next;
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    a_cnt    <= a_next;
    b_cnt    <= b_next;
    k_cnt    <= k_next;
    from_pos <= from_next;
    to_pos   <= to_next;
    fwd      <= fwd_next;
    it       <= it_next;
    pk       <= pk_next;
    pa       <= pa_next;
    delta    <= delta_next;
    accepted <= accepted_next;
    read_r   <= read_next;
  end

  // permutation memory
  always_ff @(posedge clk) begin
    if (p_we) begin
      perm_mem[p_waddr] <= p_wdata;
    end
    p_rdata <= perm_mem[p_raddr];
  end

  // weight memory
  always_ff @(posedge clk) begin
    if (w_we) begin
      weight_mem[w_waddr] <= w_wdata;
    end
    w_rdata <= weight_mem[w_raddr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      objective_value <= objective;
      move_delta      <= delta;
      move_accepted   <= accepted;
      read_item       <= read_r;
    end
  end

`ifndef SYNTHESIS
  // a taken request leaves the block busy in the cycle after
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken but block not busy next cycle");

  // an applied move always carries a strictly positive gain
  a_accept_gain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && move_accepted) |-> (!move_delta[OBJ_W-1] && move_delta != '0))
    else $error("applied move without positive gain");

  // a move result never carries a read item
  a_move_no_read: assert property (@(posedge clk) disable iff (rst)
    (out_valid && move_delta != '0) |-> (read_item == '0))
    else $error("move result with nonzero read item");

  // a result appears only after the finish step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FIN))
    else $error("result loaded outside the finish step");
`endif

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the linear ordering insertion-move engine
module tb_top;
  import loim_pkg::*;

  localparam int N_MAX = 64;
  localparam int POOL_SIZE = 8;
  localparam int QUIET_LIMIT = 40000;
  localparam int GAIN_LOOPS = 20;
  localparam int SHOWN_MAX = 50;
  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;
  localparam logic [31:0] W_MAX = 32'h7fff_ffff;
  localparam logic [31:0] W_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  row, col;
    logic [31:0]      wt;
    logic [ID_W-1:0]  pos, item, src, dst;
  } lop_req_t;

  typedef struct packed {
    logic [OBJ_W-1:0] obj;
    logic [OBJ_W-1:0] delta;
    logic             acc;
    logic [ID_W-1:0]  rd;
  } lop_res_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // configuration port
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // request channel
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   command = '0;
  logic [ID_W-1:0]    row_index = '0;
  logic [ID_W-1:0]    col_index = '0;
  logic signed [31:0] weight_value = '0;
  logic [ID_W-1:0]    position = '0;
  logic [ID_W-1:0]    item_id = '0;
  logic [ID_W-1:0]    move_from = '0;
  logic [ID_W-1:0]    move_to = '0;

  // result channel
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [OBJ_W-1:0] objective_value;
  logic signed [OBJ_W-1:0] move_delta;
  logic                    move_accepted;
  logic [ID_W-1:0]         read_item;

  linear_ordering_insertion_move i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted engine state
  logic signed [31:0] weight_mem [N_MAX*N_MAX];
  logic [ID_W-1:0]    order_mem [N_MAX];
  logic [OBJ_W-1:0]   obj_acc;
  logic [SIZE_W-1:0]  size_reg;

  lop_req_t cmd_q [$];
  lop_res_t res_due [$];
  lop_req_t cur_req;
  logic [ID_W-1:0] id_pool [POOL_SIZE];
  bit no_idle = 1'b1;
  int mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned hold_left = 0;
  int quiet = 0;

  task automatic flag_mismatch(input string what, input logic [OBJ_W-1:0] got,
                               input logic [OBJ_W-1:0] want);
    if (mismatches < SHOWN_MAX)
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // effect of one request on the predicted state, and the result it gives
  function automatic lop_res_t apply_command(lop_req_t r);
    lop_res_t o;
    int n, f, t, a, b, k;
    longint sum;
    logic [ID_W-1:0] it;
    o = '0;
    n = (int'(size_reg) > N_MAX) ? N_MAX : int'(size_reg);
    sum = 0;
    case (r.cmd)
      CMD_WR_WEIGHT: weight_mem[{r.row, r.col}] = r.wt;
      CMD_WR_PERM: order_mem[r.pos] = r.item;
      CMD_OBJECTIVE: begin
        for (a = 0; a < n; a++)
          for (b = a + 1; b < n; b++)
            sum += longint'(weight_mem[{order_mem[a], order_mem[b]}]);
        obj_acc = sum[OBJ_W-1:0];
      end
      CMD_MOVE: begin
        f = int'(r.src);
        t = int'(r.dst);
        if (f < n && t < n && f != t) begin
          it = order_mem[f];
          if (f < t) begin
            for (k = f + 1; k <= t; k++)
              sum += longint'(weight_mem[{order_mem[k], it}])
                   - longint'(weight_mem[{it, order_mem[k]}]);
          end else begin
            for (k = t; k < f; k++)
              sum += longint'(weight_mem[{it, order_mem[k]}])
                   - longint'(weight_mem[{order_mem[k], it}]);
          end
          o.delta = sum[OBJ_W-1:0];
          // strictly improving moves shift the order
          if (sum > 0) begin
            if (f < t) begin
              for (k = f; k < t; k++) order_mem[k] = order_mem[k+1];
            end else begin
              for (k = f; k > t; k--) order_mem[k] = order_mem[k-1];
            end
            order_mem[t] = it;
            obj_acc = obj_acc + sum[OBJ_W-1:0];
            o.acc = 1'b1;
          end
        end
      end
      CMD_READ: o.rd = order_mem[r.pos];
      default: ;
    endcase
    o.obj = obj_acc;
    return o;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return W_MAX;
      1: return W_MIN;
      2: return 32'($urandom_range(0, 32)) - 32'd16;
      default: return $urandom();
    endcase
  endfunction

  // an id of the pool whose weights are all written
  function automatic logic [ID_W-1:0] pick_id();
    return id_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [ID_W-1:0] pick_pos(input int eff);
    if (eff == 0 || $urandom_range(0, 6) == 0) return ID_W'($urandom());
    return ID_W'($urandom_range(0, eff - 1));
  endfunction

  // queue one request; fields the command ignores stay random
  task automatic queue_req(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] a,
                           input logic [ID_W-1:0] b, input logic [31:0] w);
    lop_req_t r;
    r.cmd  = c;
    r.row  = ID_W'($urandom());
    r.col  = ID_W'($urandom());
    r.wt   = $urandom();
    r.pos  = ID_W'($urandom());
    r.item = ID_W'($urandom());
    r.src  = ID_W'($urandom());
    r.dst  = ID_W'($urandom());
    case (c)
      CMD_WR_WEIGHT: begin
        r.row = a;
        r.col = b;
        r.wt  = w;
      end
      CMD_WR_PERM: begin
        r.pos  = a;
        r.item = b;
      end
      CMD_MOVE: begin
        r.src = a;
        r.dst = b;
      end
      CMD_READ: r.pos = a;
      default: ;
    endcase
    cmd_q.push_back(r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (cmd_q.size() != 0 || in_valid || res_due.size() != 0) @(negedge clk);
  endtask

  // register write then read back, only while the engine is idle
  task automatic set_size(input logic [SIZE_W-1:0] val);
    wait_drained();
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ACTIVE_SIZE;
    pwdata  <= {(PDATA_W-SIZE_W)'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    size_reg = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== PDATA_W'(val)) flag_mismatch("active_size readback", OBJ_W'(prdata),
                                                OBJ_W'(val));
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // random requests over the pool of written ids
  task automatic run_random(input int items);
    int eff, i, c;
    eff = (int'(size_reg) > N_MAX) ? N_MAX : int'(size_reg);
    for (i = 0; i < items; i++) begin
      // halfway through, the sender holds off until every result is back
      if (i == items / 2) wait_drained();
      c = $urandom_range(0, 99);
      if (c < 25) queue_req(CMD_WR_WEIGHT, pick_id(), pick_id(), rand_weight());
      else if (c < 40) queue_req(CMD_WR_PERM, pick_pos(eff), pick_id(), '0);
      else if (c < 75) queue_req(CMD_MOVE, pick_pos(eff), pick_pos(eff), '0);
      else if (c < 83) begin
        if (eff <= 16 || $urandom_range(0, 7) == 0) queue_req(CMD_OBJECTIVE, '0, '0, '0);
      end
      else if (c < 95) queue_req(CMD_READ, pick_pos(eff), '0, '0);
      else queue_req(CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)), '0, '0, '0);
    end
  endtask

  // request driver
  always @(posedge clk) begin : drive_req
    lop_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) res_due.push_back(apply_command(cur_req));
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (cmd_q.size() != 0) begin
          nxt = cmd_q.pop_front();
          cur_req      <= nxt;
          command      <= nxt.cmd;
          row_index    <= nxt.row;
          col_index    <= nxt.col;
          weight_value <= nxt.wt;
          position     <= nxt.pos;
          item_id      <= nxt.item;
          move_from    <= nxt.src;
          move_to      <= nxt.dst;
          in_valid     <= 1'b1;
          send_gap     <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin : check_res
    lop_res_t want;
    int unsigned g;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (res_due.size() == 0) begin
          flag_mismatch("result with nothing due", objective_value, '0);
        end else begin
          want = res_due.pop_front();
          if (objective_value !== want.obj)
            flag_mismatch("objective_value", objective_value, want.obj);
          if (move_delta !== want.delta)
            flag_mismatch("move_delta", move_delta, want.delta);
          if (move_accepted !== want.acc)
            flag_mismatch("move_accepted", OBJ_W'(move_accepted), OBJ_W'(want.acc));
          if (read_item !== want.rd)
            flag_mismatch("read_item", OBJ_W'(read_item), OBJ_W'(want.rd));
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else begin
        g = pick_gap();
        if ($urandom_range(0, 3) == 0 && g != 0) begin
          out_stall <= 1'b1;
          hold_left <= g - 1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // stimulus sequence
  initial begin : stimulus
    logic [ID_W-1:0] id_a, id_b;
    int p, q;
    size_reg = ACTIVE_SIZE_RST;
    obj_acc  = '0;
    foreach (id_pool[j]) id_pool[j] = ID_W'($urandom());
    id_pool[0] = 6'd0;
    id_pool[POOL_SIZE-1] = 6'd63;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // nothing written yet: only requests that read no store
    queue_req(CMD_RSVD_HI, '0, '0, '0);
    queue_req(CMD_MOVE, 6'd3, 6'd3, '0);

    // fill the whole order from the id pool and every pool weight pair
    for (p = 0; p < N_MAX; p++)
      queue_req(CMD_WR_PERM, ID_W'(p),
                (p == 0) ? 6'd0 : (p == N_MAX - 1) ? 6'd63 : pick_id(), '0);
    for (p = 0; p < POOL_SIZE; p++)
      for (q = 0; q < POOL_SIZE; q++)
        queue_req(CMD_WR_WEIGHT, id_pool[p], id_pool[q], rand_weight());
    wait_drained();
    no_idle = 1'b0;

    // full size: end to end moves, move onto itself, stale objective
    queue_req(CMD_OBJECTIVE, '0, '0, '0);
    queue_req(CMD_READ, 6'd0, '0, '0);
    queue_req(CMD_READ, 6'd63, '0, '0);
    queue_req(CMD_MOVE, 6'd0, 6'd63, '0);
    queue_req(CMD_MOVE, 6'd63, 6'd0, '0);
    queue_req(CMD_MOVE, 6'd10, 6'd10, '0);
    queue_req(CMD_MOVE, 6'd40, 6'd2, '0);
    queue_req(CMD_WR_WEIGHT, 6'd0, 6'd63, W_MIN);
    queue_req(CMD_WR_PERM, 6'd5, 6'd63, '0);
    queue_req(CMD_READ, 6'd5, '0, '0);
    queue_req(CMD_OBJECTIVE, '0, '0, '0);
    queue_req(CMD_RSVD_LO, '0, '0, '0);
    queue_req(CMD_RSVD_MID, '0, '0, '0);

    // smallest sizes and out of range moves
    set_size(7'd2);
    queue_req(CMD_OBJECTIVE, '0, '0, '0);
    queue_req(CMD_MOVE, 6'd0, 6'd1, '0);
    queue_req(CMD_MOVE, 6'd1, 6'd0, '0);
    queue_req(CMD_MOVE, 6'd0, 6'd2, '0);
    queue_req(CMD_MOVE, 6'd63, 6'd1, '0);
    queue_req(CMD_READ, 6'd1, '0, '0);
    set_size(7'd0);
    queue_req(CMD_OBJECTIVE, '0, '0, '0);
    queue_req(CMD_MOVE, 6'd0, 6'd1, '0);
    set_size(7'd1);
    queue_req(CMD_OBJECTIVE, '0, '0, '0);
    queue_req(CMD_MOVE, 6'd1, 6'd0, '0);
    set_size(7'd127);
    queue_req(CMD_OBJECTIVE, '0, '0, '0);
    queue_req(CMD_MOVE, 6'd63, 6'd0, '0);

    // large objective: one item that always gains from moving to the end
    set_size(7'd64);
    id_a = id_pool[0];
    id_b = id_pool[POOL_SIZE-1];
    queue_req(CMD_WR_WEIGHT, id_a, id_b, W_MIN);
    queue_req(CMD_WR_WEIGHT, id_b, id_a, W_MAX);
    queue_req(CMD_WR_WEIGHT, id_b, id_b, W_MAX);
    queue_req(CMD_WR_PERM, 6'd0, id_a, '0);
    for (p = 1; p < N_MAX; p++) queue_req(CMD_WR_PERM, ID_W'(p), id_b, '0);
    queue_req(CMD_OBJECTIVE, '0, '0, '0);
    repeat (GAIN_LOOPS) begin
      queue_req(CMD_MOVE, 6'd0, 6'd63, '0);
      queue_req(CMD_WR_PERM, 6'd0, id_a, '0);
      queue_req(CMD_WR_PERM, 6'd63, id_b, '0);
    end
    queue_req(CMD_READ, 6'd0, '0, '0);
    queue_req(CMD_OBJECTIVE, '0, '0, '0);

    // random phases, mostly small sizes
    set_size(7'($urandom_range(2, 8)));
    run_random(40);
    set_size(7'($urandom_range(2, 16)));
    run_random(40);
    set_size(7'($urandom_range(3, 6)));
    no_idle = 1'b1;
    run_random(40);
    wait_drained();
    no_idle = 1'b0;
    set_size(7'd64);
    run_random(30);
    set_size(7'($urandom_range(65, 127)));
    run_random(25);
    set_size(7'($urandom_range(0, 5)));
    run_random(40);
    set_size(7'($urandom_range(2, 8)));
    run_random(40);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/loim_pkg.sv
rtl/loim_alu.sv
rtl/linear_ordering_insertion_move.sv
dv/tb_top.sv
